>>> rtl/core/json_key_value_tokenizer_core_assert.svh
// Assertion macros used by the tokenizer event queue.
`ifndef JSON_KEY_VALUE_TOKENIZER_CORE_ASSERT_SVH
`define JSON_KEY_VALUE_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JKVT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JKVT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/jkvt_pkg.sv
package jkvt_pkg;

    // Default sizing
    localparam int KEY_SIZE_DEF  = 32;
    localparam int PAIR_CAP_DEF  = 64;
    localparam int MAX_DEPTH_DEF = 16;
    localparam int MAX_LEN_DEF   = 65536;

    // Field widths
    localparam int PAIR_W  = 6;
    localparam int POS_W   = 16;
    localparam int DEPTH_W = 4;
    localparam int LIMIT_W = 7;

    // Events one input byte can cause at most
    localparam int EV_SLOTS = 3;
    localparam int CNT_W    = 2;

    // Characters with a meaning
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    typedef enum logic [2:0] {
        EV_KEY_BYTE   = 3'd0,
        EV_KEY_DONE   = 3'd1,
        EV_VAL_START  = 3'd2,
        EV_VAL_END    = 3'd3,
        EV_OBJ_CLOSED = 3'd4,
        EV_COMPLETE   = 3'd5,
        EV_ERROR      = 3'd6,
        EV_BUF_END    = 3'd7
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t            kind;
        logic [PAIR_W-1:0]   pair;
        logic [POS_W-1:0]    pos;
        logic [DEPTH_W-1:0]  depth;
        logic [7:0]          data;
        logic                from_stack;   // pair comes from the open-object stack
    } event_t;

    typedef struct packed {
        event_t [EV_SLOTS-1:0] ev;
        logic [CNT_W-1:0]      cnt;
    } bundle_t;

    function automatic event_t make_ev(
        input ev_kind_t           kind,
        input logic [PAIR_W-1:0]  pair,
        input logic [POS_W-1:0]   pos,
        input logic [DEPTH_W-1:0] depth,
        input logic [7:0]         data,
        input logic               from_stack
    );
        event_t e;
        e.kind       = kind;
        e.pair       = pair;
        e.pos        = pos;
        e.depth      = depth;
        e.data       = data;
        e.from_stack = from_stack;
        return e;
    endfunction

endpackage

>>> rtl/core/jkvt_evq.sv
module jkvt_evq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  jkvt_pkg::bundle_t        bundle,
    input  logic [jkvt_pkg::PAIR_W-1:0] stack_pair,
    output logic                     ready,
    output logic                     out_valid,
    input  logic                     out_stall,
    output jkvt_pkg::event_t         out_ev,
    output logic                     out_last
);
    import jkvt_pkg::*;

    event_t [EV_SLOTS-1:0] bq_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      head_reg;
    logic                  out_valid_reg;
    event_t                out_ev_reg;
    logic                  out_last_reg;

    logic   out_free;
    logic   move;
    logic   head_last;
    event_t head_ev;

    // Pick the next event and patch in the stack pair when needed
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        move      = (cnt_reg != '0) && out_free;
        head_last = (head_reg == (cnt_reg - CNT_W'(1)));
        head_ev   = bq_reg[head_reg];
        if (head_ev.from_stack)
        begin
            head_ev.pair = stack_pair;
        end
        head_ev.from_stack = 1'b0;
    end

    // Accept a new bundle once the held one is fully handed on
    assign ready = (cnt_reg == '0) || (move && head_last);

    // Advance bundle and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (move)
            begin
                out_valid_reg <= 1'b1;
                head_reg      <= head_reg + CNT_W'(1);
                if (head_last)
                begin
                    cnt_reg <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                cnt_reg  <= bundle.cnt;
                head_reg <= '0;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_ev_reg   <= head_ev;
            out_last_reg <= head_last;
        end
        if (load)
        begin
            bq_reg <= bundle.ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_ev_reg;
    assign out_last  = out_last_reg;

`include "json_key_value_tokenizer_core_assert.svh"

    `JKVT_ASSERT_IMP(a_head_in_range, cnt_reg != '0, head_reg < cnt_reg, "head past bundle end")
    `JKVT_ASSERT_IMP(a_load_when_free, load, ready, "bundle overwritten before drained")
    `JKVT_ASSERT_NXT(a_move_shows, move, out_valid_reg, "moved event not presented")

endmodule

>>> rtl/core/json_key_value_tokenizer_core.sv
// JSON key/value tokenizer: takes one byte of JSON text per transfer and emits
// key/value events (key byte, key done, value start/end, object closed,
// complete, error, buffer ended), one event per output transfer. A byte is
// taken every cycle as long as each byte causes at most one event and the
// output is not stalled; a byte causing several events (up to three) holds the
// input until the event serializer has handed them all on, one a cycle while
// the output is not stalled. An enclosing object's pair index is kept in a
// small stack memory with a registered read, fetched when its closing brace is
// taken and used when its close event moves out; no clearing pass follows
// reset. pairs_limit may only be written while the block is idle; after a byte
// marked last_byte the parser re-arms for a new document and keeps pairs_limit.
module json_key_value_tokenizer_core #(
    parameter int KEY_SIZE  = jkvt_pkg::KEY_SIZE_DEF,
    parameter int PAIR_CAP  = jkvt_pkg::PAIR_CAP_DEF,
    parameter int MAX_DEPTH = jkvt_pkg::MAX_DEPTH_DEF,
    parameter int MAX_LEN   = jkvt_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jkvt_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    event_kind,
    output logic [jkvt_pkg::PAIR_W-1:0]   pair_index,
    output logic [jkvt_pkg::POS_W-1:0]    position,
    output logic [jkvt_pkg::DEPTH_W-1:0]  nest_depth,
    output logic [7:0]                    event_byte,
    output logic                          last_of_run
);
    import jkvt_pkg::*;

    localparam int PCW = $clog2(PAIR_CAP + 1);
    localparam int DCW = $clog2(MAX_DEPTH + 1);
    localparam int SAW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int KLW = $clog2(KEY_SIZE);
    localparam int OW  = $clog2(MAX_LEN);

    typedef enum logic [9:0] {
        ST_INIT     = 10'b00_0000_0001,
        ST_KEY      = 10'b00_0000_0010,
        ST_KEY_STR  = 10'b00_0000_0100,
        ST_KEY_END  = 10'b00_0000_1000,
        ST_VALUE    = 10'b00_0001_0000,
        ST_VAL_STR  = 10'b00_0010_0000,
        ST_VAL_END  = 10'b00_0100_0000,
        ST_VAL_BARE = 10'b00_1000_0000,
        ST_CRASHED  = 10'b01_0000_0000,
        ST_COMPLETE = 10'b10_0000_0000
    } pstate_t;

    pstate_t                st_reg, st_next;
    logic [DCW-1:0]         open_reg, open_next;     // brace level plus one
    logic [PCW-1:0]         pc_reg, pc_next;
    logic [KLW-1:0]         kl_reg, kl_next;
    logic [OW-1:0]          off_reg, off_next;
    logic                   stop_reg, stop_next;
    logic [LIMIT_W-1:0]     limit_reg;

    logic [PAIR_W-1:0]      stack_mem [MAX_DEPTH];
    logic [PAIR_W-1:0]      stack_rd_reg;

    logic                   in_ready;
    logic                   in_accept;
    logic                   push;
    logic                   pop;
    logic [SAW-1:0]         wr_addr;
    logic [SAW-1:0]         rd_addr;
    bundle_t                bundle;
    event_t                 out_ev;
    logic                   out_last;

    logic [31:0]            open_m1;
    logic [31:0]            open_m2;
    logic [PAIR_W-1:0]      cur_pair;
    logic [DEPTH_W-1:0]     cur_depth;
    logic [POS_W-1:0]       pos;
    logic [POS_W-1:0]       prev_pos;
    logic [OW-1:0]          prev_off;
    logic                   limit_hit;

    function automatic logic [PAIR_W-1:0] pair_of(input logic [PCW-1:0] pc);
        logic [31:0] pm1;
        pm1 = 32'(pc) - 32'd1;
        return (pc == '0) ? '0 : pm1[PAIR_W-1:0];
    endfunction

    function automatic logic [DEPTH_W-1:0] depth_of(input logic [DCW-1:0] oc);
        logic [31:0] om1;
        om1 = 32'(oc) - 32'd1;
        return (oc == '0) ? '0 : om1[DEPTH_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_of(input logic [OW-1:0] off);
        logic [OW+POS_W-1:0] wide;
        wide = {{POS_W{1'b0}}, off};
        return wide[POS_W-1:0];
    endfunction

    // Configuration: always ready; the user must write it only while idle, the block does not check this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(PAIR_CAP_DEF);
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Derive current-byte quantities
    always_comb
    begin
        open_m1   = 32'(open_reg) - 32'd1;
        open_m2   = 32'(open_reg) - 32'd2;
        wr_addr   = open_m1[SAW-1:0];
        rd_addr   = open_m2[SAW-1:0];
        cur_pair  = pair_of(pc_reg);
        cur_depth = depth_of(open_reg);
        pos       = pos_of(off_reg);
        prev_off  = (off_reg == '0) ? OW'(MAX_LEN - 1) : (off_reg - OW'(1));
        prev_pos  = pos_of(prev_off);
        limit_hit = (32'(pc_reg) >= 32'(limit_reg)) || (32'(pc_reg) >= 32'(PAIR_CAP));
    end

    // Parse step: next state and the events of this byte
    always_comb
    begin
        logic         fail;
        logic [1:0]   n;
        event_t [EV_SLOTS-1:0] ev;

        st_next   = st_reg;
        open_next = open_reg;
        pc_next   = pc_reg;
        kl_next   = kl_reg;
        stop_next = stop_reg;
        off_next  = off_reg;
        push      = 1'b0;
        pop       = 1'b0;
        fail      = 1'b0;
        n         = '0;
        ev        = '0;

        if (!stop_reg)
        begin
            priority if (data_byte == CH_SPACE)
            begin
                if (st_reg == ST_VAL_BARE)
                begin
                    ev[0]   = make_ev(EV_VAL_END, cur_pair, prev_pos, cur_depth,
                                      data_byte, 1'b0);
                    n       = 2'd1;
                    st_next = ST_VAL_END;
                end
            end
            else if (data_byte == CH_LBRACE)
            begin
                if (open_reg == '0)
                begin
                    open_next = DCW'(1);
                end
                else if ((pc_reg == '0) || (32'(open_reg) >= 32'(MAX_DEPTH)))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    ev[0]     = make_ev(EV_VAL_START, cur_pair, pos, cur_depth,
                                        data_byte, 1'b0);
                    n         = 2'd1;
                    push      = 1'b1;
                    open_next = open_reg + DCW'(1);
                    st_next   = ST_INIT;
                end
            end
            else if (data_byte == CH_RBRACE)
            begin
                if ((open_reg == '0) || !((st_reg == ST_INIT) || (st_reg == ST_VAL_END)
                    || (st_reg == ST_VAL_BARE)))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    if (st_reg == ST_VAL_BARE)
                    begin
                        ev[0] = make_ev(EV_VAL_END, cur_pair, prev_pos, cur_depth,
                                        data_byte, 1'b0);
                        n     = 2'd1;
                    end
                    open_next = open_reg - DCW'(1);
                    st_next   = ST_INIT;
                    if (open_reg == DCW'(1))
                    begin
                        ev[n]     = make_ev(EV_COMPLETE, cur_pair, pos, '0,
                                            data_byte, 1'b0);
                        n         = n + 2'd1;
                        st_next   = ST_COMPLETE;
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        ev[n] = make_ev(EV_OBJ_CLOSED, '0, pos,
                                        depth_of(open_reg - DCW'(1)), data_byte, 1'b1);
                        n     = n + 2'd1;
                        pop   = 1'b1;
                    end
                end
            end
            else if (data_byte == CH_COLON)
            begin
                if (st_reg == ST_KEY_END)
                begin
                    st_next = ST_VALUE;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (data_byte == CH_COMMA)
            begin
                if (st_reg == ST_VAL_BARE)
                begin
                    ev[0]   = make_ev(EV_VAL_END, cur_pair, prev_pos, cur_depth,
                                      data_byte, 1'b0);
                    n       = 2'd1;
                    st_next = ST_INIT;
                end
                else if ((st_reg == ST_INIT) || (st_reg == ST_VAL_END))
                begin
                    st_next = ST_INIT;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (data_byte == CH_QUOTE)
            begin
                unique case (st_reg)
                    ST_INIT:
                    begin
                        if (limit_hit)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            pc_next = pc_reg + PCW'(1);
                            kl_next = '0;
                            st_next = ST_KEY;
                        end
                    end
                    ST_KEY_STR:
                    begin
                        ev[0]   = make_ev(EV_KEY_DONE, cur_pair, pos, cur_depth,
                                          data_byte, 1'b0);
                        n       = 2'd1;
                        kl_next = '0;
                        st_next = ST_KEY_END;
                    end
                    ST_VALUE:
                    begin
                        ev[0]   = make_ev(EV_VAL_START, cur_pair, pos, cur_depth,
                                          data_byte, 1'b0);
                        n       = 2'd1;
                        st_next = ST_VAL_STR;
                    end
                    ST_VAL_STR:
                    begin
                        ev[0]   = make_ev(EV_VAL_END, cur_pair, pos, cur_depth,
                                          data_byte, 1'b0);
                        n       = 2'd1;
                        st_next = ST_VAL_END;
                    end
                    default:
                    begin
                        fail = 1'b1;
                    end
                endcase
            end
            else
            begin
                unique case (st_reg)
                    ST_KEY, ST_KEY_STR:
                    begin
                        if (32'(kl_reg) < (KEY_SIZE - 1))
                        begin
                            ev[0]   = make_ev(EV_KEY_BYTE, cur_pair, pos, cur_depth,
                                              data_byte, 1'b0);
                            n       = 2'd1;
                            kl_next = kl_reg + KLW'(1);
                        end
                        st_next = ST_KEY_STR;
                    end
                    ST_VALUE:
                    begin
                        ev[0]   = make_ev(EV_VAL_START, cur_pair, pos, cur_depth,
                                          data_byte, 1'b0);
                        n       = 2'd1;
                        st_next = ST_VAL_BARE;
                    end
                    ST_VAL_STR, ST_VAL_BARE:
                    begin
                        st_next = st_reg;
                    end
                    default:
                    begin
                        fail = 1'b1;
                    end
                endcase
            end

            // Drop into the crashed state on any parse error
            if (fail)
            begin
                ev[0]     = make_ev(EV_ERROR, cur_pair, pos, cur_depth, data_byte, 1'b0);
                n         = 2'd1;
                st_next   = ST_CRASHED;
                stop_next = 1'b1;
            end
        end

        // End of buffer: report, then re-arm
        if (last_byte)
        begin
            ev[n]     = make_ev(EV_BUF_END, pair_of(pc_next), pos, depth_of(open_next),
                                data_byte, 1'b0);
            n         = n + 2'd1;
            st_next   = ST_INIT;
            open_next = '0;
            pc_next   = '0;
            kl_next   = '0;
            off_next  = '0;
            stop_next = 1'b0;
        end
        else
        begin
            off_next = (32'(off_reg) == (MAX_LEN - 1)) ? '0 : (off_reg + OW'(1));
        end

        bundle.ev  = ev;
        bundle.cnt = n;
    end

    assign in_accept = in_valid && in_ready;
    assign in_stall  = !in_ready;

    // Advance parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_INIT;
            open_reg <= '0;
            pc_reg   <= '0;
            kl_reg   <= '0;
            off_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            st_reg   <= st_next;
            open_reg <= open_next;
            pc_reg   <= pc_next;
            kl_reg   <= kl_next;
            off_reg  <= off_next;
            stop_reg <= stop_next;
        end
    end

    // Open-object stack: push on a nested brace, read on its close
    always_ff @(posedge clk)
    begin
        if (in_accept && push)
        begin
            stack_mem[wr_addr] <= cur_pair;
        end
        if (in_accept && pop)
        begin
            stack_rd_reg <= stack_mem[rd_addr];
        end
    end

    jkvt_evq u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept && (bundle.cnt != '0)),
        .bundle     (bundle),
        .stack_pair (stack_rd_reg),
        .ready      (in_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_ev     (out_ev),
        .out_last   (out_last)
    );

    assign event_kind  = out_ev.kind;
    assign pair_index  = out_ev.pair;
    assign position    = out_ev.pos;
    assign nest_depth  = out_ev.depth;
    assign event_byte  = out_ev.data;
    assign last_of_run = out_last;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jkvt_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int CFG_PAUSE  = 8;
    localparam int END_PAUSE  = 20;

    // Parse machine phases, mirrored for prediction
    typedef enum logic [3:0] {
        ST_INIT, ST_KEY, ST_KEY_STR, ST_KEY_END, ST_VALUE,
        ST_VAL_STR, ST_VAL_END, ST_VAL_BARE, ST_CRASHED, ST_COMPLETE
    } scan_state_t;

    typedef struct packed {
        ev_kind_t            kind;
        logic [PAIR_W-1:0]   pair;
        logic [POS_W-1:0]    pos;
        logic [DEPTH_W-1:0]  depth;
        logic [7:0]          data;
        logic                tail;
    } pair_event_t;

    // Tracks the document parse and holds the events still owed by the block
    class pair_event_tracker;
        logic [LIMIT_W-1:0] pairs_limit;
        scan_state_t        scan;
        int                 level;
        int                 pairs;
        int                 key_len;
        logic [POS_W-1:0]   offset;
        logic [PAIR_W-1:0]  open_pairs [MAX_DEPTH_DEF];
        bit                 halted;
        pair_event_t        pending [$];
        pair_event_t        run [$];
        int                 failures;

        function new();
            pairs_limit = 7'd64;
            failures = 0;
            rearm();
        endfunction

        function void rearm();
            scan = ST_INIT;
            level = -1;
            pairs = 0;
            key_len = 0;
            offset = '0;
            halted = 1'b0;
        endfunction

        function logic [PAIR_W-1:0] cur_pair();
            return (pairs == 0) ? '0 : PAIR_W'(pairs - 1);
        endfunction

        function logic [DEPTH_W-1:0] cur_depth();
            return (level < 0) ? '0 : DEPTH_W'(level);
        endfunction

        function void add(ev_kind_t k, logic [PAIR_W-1:0] p, logic [POS_W-1:0] pos,
                          logic [DEPTH_W-1:0] d, logic [7:0] c);
            pair_event_t e;
            e.kind = k;
            e.pair = p;
            e.pos = pos;
            e.depth = d;
            e.data = c;
            e.tail = 1'b0;
            run.push_back(e);
        endfunction

        function void crash(logic [POS_W-1:0] pos, logic [7:0] c);
            add(EV_ERROR, cur_pair(), pos, cur_depth(), c);
            scan = ST_CRASHED;
            halted = 1'b1;
        endfunction

        // Advance the parse machine by one byte
        function void scan_byte(logic [7:0] c);
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] prev;
            int lim;
            pos = offset;
            prev = offset - 1'b1;
            lim = (pairs_limit < PAIR_CAP_DEF) ? int'(pairs_limit) : PAIR_CAP_DEF;
            case (c)
                CH_SPACE: begin
                    if (scan == ST_VAL_BARE) begin
                        add(EV_VAL_END, cur_pair(), prev, cur_depth(), c);
                        scan = ST_VAL_END;
                    end
                end
                CH_LBRACE: begin
                    if (level < 0) begin
                        level = 0;
                    end else if (pairs == 0 || level >= MAX_DEPTH_DEF - 1) begin
                        crash(pos, c);
                    end else begin
                        add(EV_VAL_START, cur_pair(), pos, cur_depth(), c);
                        open_pairs[level % MAX_DEPTH_DEF] = cur_pair();
                        level++;
                        scan = ST_INIT;
                    end
                end
                CH_RBRACE: begin
                    if (level < 0 || (scan != ST_INIT && scan != ST_VAL_END &&
                                      scan != ST_VAL_BARE)) begin
                        crash(pos, c);
                    end else begin
                        if (scan == ST_VAL_BARE)
                            add(EV_VAL_END, cur_pair(), prev, cur_depth(), c);
                        level--;
                        scan = ST_INIT;
                        if (level < 0) begin
                            add(EV_COMPLETE, cur_pair(), pos, '0, c);
                            scan = ST_COMPLETE;
                            halted = 1'b1;
                        end else begin
                            add(EV_OBJ_CLOSED, open_pairs[level % MAX_DEPTH_DEF], pos,
                                cur_depth(), c);
                        end
                    end
                end
                CH_COLON: begin
                    if (scan == ST_KEY_END)
                        scan = ST_VALUE;
                    else
                        crash(pos, c);
                end
                CH_COMMA: begin
                    if (scan == ST_VAL_BARE) begin
                        add(EV_VAL_END, cur_pair(), prev, cur_depth(), c);
                        scan = ST_INIT;
                    end else if (scan == ST_INIT || scan == ST_VAL_END) begin
                        scan = ST_INIT;
                    end else begin
                        crash(pos, c);
                    end
                end
                CH_QUOTE: begin
                    case (scan)
                        ST_INIT: begin
                            if (pairs >= lim) begin
                                crash(pos, c);
                            end else begin
                                pairs++;
                                key_len = 0;
                                scan = ST_KEY;
                            end
                        end
                        ST_KEY_STR: begin
                            add(EV_KEY_DONE, cur_pair(), pos, cur_depth(), c);
                            key_len = 0;
                            scan = ST_KEY_END;
                        end
                        ST_VALUE: begin
                            add(EV_VAL_START, cur_pair(), pos, cur_depth(), c);
                            scan = ST_VAL_STR;
                        end
                        ST_VAL_STR: begin
                            add(EV_VAL_END, cur_pair(), pos, cur_depth(), c);
                            scan = ST_VAL_END;
                        end
                        default: crash(pos, c);
                    endcase
                end
                default: begin
                    case (scan)
                        ST_KEY, ST_KEY_STR: begin
                            // Keep long keys open but stop reporting their bytes
                            if (key_len < KEY_SIZE_DEF - 1) begin
                                add(EV_KEY_BYTE, cur_pair(), pos, cur_depth(), c);
                                key_len++;
                            end
                            scan = ST_KEY_STR;
                        end
                        ST_VALUE: begin
                            add(EV_VAL_START, cur_pair(), pos, cur_depth(), c);
                            scan = ST_VAL_BARE;
                        end
                        ST_VAL_STR, ST_VAL_BARE: ;
                        default: crash(pos, c);
                    endcase
                end
            endcase
        endfunction

        // Note one accepted byte and queue the events it causes
        function void take_byte(logic [7:0] c, logic last);
            run.delete();
            if (!halted)
                scan_byte(c);
            if (last) begin
                add(EV_BUF_END, cur_pair(), offset, cur_depth(), c);
                rearm();
            end else begin
                offset++;
            end
            if (run.size() > 0)
                run[run.size() - 1].tail = 1'b1;
            foreach (run[i])
                pending.push_back(run[i]);
        endfunction

        // Compare one accepted event with the oldest one owed
        function void match_event(logic [2:0] kind, logic [PAIR_W-1:0] pair,
                                  logic [POS_W-1:0] pos, logic [DEPTH_W-1:0] depth,
                                  logic [7:0] data, logic tail);
            pair_event_t e;
            if (pending.size() == 0) begin
                $error("unexpected event: event_kind %0d position %0d", kind, pos);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $error("event_kind: expected %0d, got %0d", e.kind, kind);
                failures++;
            end
            if (pair !== e.pair) begin
                $error("pair_index: expected %0d, got %0d", e.pair, pair);
                failures++;
            end
            if (pos !== e.pos) begin
                $error("position: expected %0d, got %0d", e.pos, pos);
                failures++;
            end
            if (depth !== e.depth) begin
                $error("nest_depth: expected %0d, got %0d", e.depth, depth);
                failures++;
            end
            if (data !== e.data) begin
                $error("event_byte: expected 0x%02h, got 0x%02h", e.data, data);
                failures++;
            end
            if (tail !== e.tail) begin
                $error("last_of_run: expected %0d, got %0d", e.tail, tail);
                failures++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = '0;
    logic               last_byte = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         event_kind;
    logic [PAIR_W-1:0]  pair_index;
    logic [POS_W-1:0]   position;
    logic [DEPTH_W-1:0] nest_depth;
    logic [7:0]         event_byte;
    logic               last_of_run;

    pair_event_tracker board;
    logic [7:0]        text [$];
    bit                quiet = 1'b0;
    int                fed = 0;
    int                idle_cycles = 0;

    json_key_value_tokenizer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .pair_index  (pair_index),
        .position    (position),
        .nest_depth  (nest_depth),
        .event_byte  (event_byte),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic bit is_special(logic [7:0] c);
        return c == CH_SPACE || c == CH_LBRACE || c == CH_RBRACE ||
               c == CH_COLON || c == CH_COMMA || c == CH_QUOTE;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_special(c));
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 11))
            0: return CH_SPACE;
            1: return CH_LBRACE;
            2: return CH_RBRACE;
            3: return CH_COLON;
            4: return CH_COMMA;
            5: return CH_QUOTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_str(string s);
        foreach (s[i])
            text.push_back(s[i]);
    endfunction

    function automatic void add_spaces();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text.push_back(CH_SPACE);
    endfunction

    function automatic void add_key();
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
        text.push_back(CH_QUOTE);
        repeat (len) text.push_back(plain_char());
        text.push_back(CH_QUOTE);
    endfunction

    // Build one well-formed document; open objects are kept on a queue
    function automatic void add_document();
        int left [$];
        bit opened [$];
        int r;
        add_spaces();
        text.push_back(CH_LBRACE);
        left.push_back($urandom_range(0, 3));
        opened.push_back(1'b0);
        while (left.size() > 0) begin
            if (left[left.size() - 1] == 0) begin
                text.push_back(CH_RBRACE);
                void'(left.pop_back());
                void'(opened.pop_back());
                add_spaces();
                continue;
            end
            if (opened[opened.size() - 1])
                text.push_back(CH_COMMA);
            opened[opened.size() - 1] = 1'b1;
            left[left.size() - 1]--;
            add_spaces();
            add_key();
            add_spaces();
            text.push_back(CH_COLON);
            add_spaces();
            r = $urandom_range(0, 99);
            if (left.size() < 4 && r < 20) begin
                text.push_back(CH_LBRACE);
                left.push_back($urandom_range(0, 3));
                opened.push_back(1'b0);
                continue;
            end else if (r < 55) begin
                text.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5))
                    text.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : plain_char());
                text.push_back(CH_QUOTE);
            end else begin
                repeat ($urandom_range(1, 4)) text.push_back(plain_char());
            end
            add_spaces();
        end
    endfunction

    // Chain of nested objects near and past the depth limit
    function automatic void add_deep_chain();
        int d;
        d = $urandom_range(12, 16);
        text.push_back(CH_LBRACE);
        repeat (d) begin
            text.push_back(CH_QUOTE);
            text.push_back(plain_char());
            text.push_back(CH_QUOTE);
            text.push_back(CH_COLON);
            text.push_back(CH_LBRACE);
        end
        repeat (d + 1) text.push_back(CH_RBRACE);
    endfunction

    // Damage a document: replace, drop or cut at one spot
    function automatic void break_text();
        int idx;
        idx = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 2))
            0: text[idx] = any_char();
            1: text.delete(idx);
            default: text = text[0:idx];
        endcase
    endfunction

    // Offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= c;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fed++;
        board.take_byte(c, last);
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
        text.delete();
    endtask

    // Drain the block, then write pairs_limit
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (CFG_PAUSE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.pairs_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_batch(input int target);
        int start;
        int r;
        int n;
        start = fed;
        while (fed - start < target) begin
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 82) begin
                if (r < 65)
                    add_document();
                else if (r < 75) begin
                    add_document();
                    break_text();
                end else
                    add_deep_chain();
                send_text();
            end else begin
                // Noise burst, special characters weighted up
                n = $urandom_range(3, 10);
                for (int i = 0; i < n; i++)
                    send_byte(any_char(), i == n - 1 || $urandom_range(0, 7) == 0);
            end
        end
        quiet = 1'b0;
    endtask

    // Output side: random stalls, none while quiet
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (!quiet)
                    stall_left = pick_gap();
            end
        end
    end

    // Check each event transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.match_event(event_kind, pair_index, position, nest_depth, event_byte,
                              last_of_run);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: nested pair, close by brace, string value, then error cases
        add_str("{\"a\":{\"b\":7},\"c\":\"x\"}");
        send_text();
        add_str("{{");
        send_text();
        add_str("}");
        send_text();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        write_limit(7'd1);
        run_batch(25);
        write_limit(7'd0);
        run_batch(15);
        write_limit(7'd127);
        run_batch(25);
        write_limit(7'd2);
        run_batch(20);
        write_limit(LIMIT_W'($urandom_range(3, 63)));
        run_batch(20);
        write_limit(7'd64);
        run_batch(15);

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (END_PAUSE) @(negedge clk);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> json_key_value_tokenizer_core.f
+incdir+rtl/core
rtl/core/jkvt_pkg.sv
rtl/core/jkvt_evq.sv
rtl/core/json_key_value_tokenizer_core.sv
tb/sv/testbench.sv
